### rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg: shared constants and arithmetic helpers
// Widths, coefficient slot codes and the Q2.22 rounding of the biquad cascade.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int MAX_SECTIONS  = 32;
  localparam int SLOTS         = 6;
  localparam int SEC_W         = $clog2(MAX_SECTIONS);
  localparam int CNT_W         = SEC_W + 1;
  localparam int COEF_DEPTH    = SLOTS * MAX_SECTIONS;
  localparam int COEF_AW       = $clog2(COEF_DEPTH);
  localparam int COEF_W        = 24;
  localparam int HIST_W        = 32;
  localparam int SAMPLE_W      = 16;
  localparam int Q_COEF        = 22;
  localparam int PROD_W        = COEF_W + HIST_W;
  localparam int ACC_W         = PROD_W + 4;
  localparam int RESET_COUNT   = 15;

  // coefficient slot codes
  localparam logic [2:0] SLOT_B0   = 3'd0;
  localparam logic [2:0] SLOT_B1   = 3'd1;
  localparam logic [2:0] SLOT_B2   = 3'd2;
  localparam logic [2:0] SLOT_A1   = 3'd3;
  localparam logic [2:0] SLOT_A2   = 3'd4;
  localparam logic [2:0] SLOT_GAIN = 3'd5;

  // product step codes within one section
  localparam logic [2:0] PR_GAIN = 3'd0;
  localparam logic [2:0] PR_A1   = 3'd1;
  localparam logic [2:0] PR_A2   = 3'd2;
  localparam logic [2:0] PR_B0   = 3'd3;
  localparam logic [2:0] PR_B1   = 3'd4;
  localparam logic [2:0] PR_B2   = 3'd5;

  function automatic logic [2:0] prod_slot(input logic [2:0] prod);
    logic [2:0] s;
    unique case (prod)
      PR_GAIN: s = SLOT_GAIN;
      PR_A1:   s = SLOT_A1;
      PR_A2:   s = SLOT_A2;
      PR_B0:   s = SLOT_B0;
      PR_B1:   s = SLOT_B1;
      PR_B2:   s = SLOT_B2;
      default: s = SLOT_B0;
    endcase
    return s;
  endfunction

  // round to nearest (ties up), drop Q_COEF bits, saturate to 32 bits
  function automatic logic signed [HIST_W-1:0] round_q22(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0]        t;
    logic signed [ACC_W-Q_COEF-1:0] s;
    logic signed [HIST_W-1:0]       r;
    t = a + (ACC_W'(1) <<< (Q_COEF - 1));
    s = t[ACC_W-1:Q_COEF];
    if (s > (ACC_W-Q_COEF)'(signed'({1'b0, {(HIST_W-1){1'b1}}}))) begin
      r = {1'b0, {(HIST_W-1){1'b1}}};
    end else if (s < (ACC_W-Q_COEF)'(signed'({1'b1, {(HIST_W-1){1'b0}}}))) begin
      r = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      r = s[HIST_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/sic_ram.sv
// ----------------------------------------------------------------------------
// sic_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sos_iir_cascade_unit.sv
// ----------------------------------------------------------------------------
// sos_iir_cascade_unit: cascade of direct-form-II biquad sections
// Bit-serial shift-add multiplier walks each section's six products.
// ----------------------------------------------------------------------------
// Each product runs coefficient read, latch, 24 one-bit steps of
//   the shift-add multiplier and accumulate; a rounding step follows
//   the gain, a2 and b2 products of each section. One item at a time.
// Reset clears control state and history valid bits and sets the section count to 15.
module sos_iir_cascade_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,     // section_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] sample_in, [20:16] section_index, [23:21] coef_slot, [47:24] coef_value
  input  logic [47:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // sample_out
  output logic        m_axis_tuser_o   // saturated
);
  import sic_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_LAT  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CNT_W-1:0] count_q, n_q, n_d;
  logic [SEC_W-1:0] sec_q, sec_d;
  logic [2:0] prod_q, prod_d;
  logic [4:0] bit_q, bit_d;
  logic [COEF_W-1:0] cbits_q, cbits_d;
  logic signed [HIST_W-1:0] x_q, x_d, w0_q, w0_d, h0_q, h0_d, h1_q, h1_d, v_q, v_d;
  logic signed [PROD_W-1:0] p_q, p_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [MAX_SECTIONS-1:0] hv_q, hv_d;
  logic out_valid_q, out_valid_d, out_sat_q, out_sat_d;
  logic [SAMPLE_W-1:0] out_data_q, out_data_d;

  logic in_xfer, out_free;
  logic coef_we;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic [COEF_W-1:0] coef_rdata;
  logic hist_we;
  logic [2*HIST_W-1:0] hist_rdata;
  logic signed [HIST_W-1:0] rnd;
  logic signed [PROD_W-1:0] addend;
  logic signed [HIST_W:0] fin_t;
  logic signed [SAMPLE_W:0] fin_r;

  logic [SAMPLE_W-1:0] in_sample;
  logic [SEC_W-1:0] in_sec;
  logic [2:0] in_slot;
  logic [COEF_W-1:0] in_coef;

  assign in_sample = s_axis_tdata_i[15:0];
  assign in_sec    = s_axis_tdata_i[20:16];
  assign in_slot   = s_axis_tdata_i[23:21];
  assign in_coef   = s_axis_tdata_i[47:24];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign coef_we    = in_xfer && s_axis_tuser_i && (in_slot < 3'(SLOTS));
  assign coef_waddr = COEF_AW'(in_sec) * COEF_AW'(SLOTS) + COEF_AW'(in_slot);
  assign coef_raddr = COEF_AW'(sec_q) * COEF_AW'(SLOTS) + COEF_AW'(prod_slot(prod_q));
  assign hist_we    = (state_q == ST_RND) && (prod_q == PR_B2);

  sic_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_coef),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  sic_ram #(.WIDTH(2 * HIST_W), .DEPTH(MAX_SECTIONS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (sec_q),
    .wdata_i ({h0_q, w0_q}),
    .raddr_i (sec_q),
    .rdata_o (hist_rdata)
  );

  assign rnd    = round_q22(acc_q);
  assign addend = cbits_q[COEF_W-1] ?
                  ((bit_q == 5'd0) ? -PROD_W'(v_q) : PROD_W'(v_q)) : '0;
  assign fin_t  = (HIST_W+1)'(x_q) + (HIST_W+1)'(32768);
  assign fin_r  = fin_t[HIST_W:SAMPLE_W];

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    sec_d       = sec_q;
    prod_d      = prod_q;
    bit_d       = bit_q;
    cbits_d     = cbits_q;
    x_d         = x_q;
    w0_d        = w0_q;
    h0_d        = h0_q;
    h1_d        = h1_q;
    v_d         = v_q;
    p_d         = p_q;
    acc_d       = acc_q;
    hv_d        = hv_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_sat_d   = out_sat_q;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && !s_axis_tuser_i) begin
          if (count_q == '0) begin
            out_valid_d = 1'b1;
            out_data_d  = in_sample;
            out_sat_d   = 1'b0;
          end else begin
            n_d     = (count_q > CNT_W'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS) : count_q;
            x_d     = {in_sample, 16'h0};
            sec_d   = '0;
            prod_d  = PR_GAIN;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: state_d = ST_LAT;
      ST_LAT: begin
        cbits_d = coef_rdata;
        p_d     = '0;
        bit_d   = '0;
        if (prod_q == PR_GAIN) begin
          h0_d = hv_q[sec_q] ? hist_rdata[HIST_W-1:0] : '0;
          h1_d = hv_q[sec_q] ? hist_rdata[2*HIST_W-1:HIST_W] : '0;
        end
        unique case (prod_q)
          PR_GAIN:       v_d = x_q;
          PR_A1, PR_B1:  v_d = h0_q;
          PR_A2, PR_B2:  v_d = h1_q;
          PR_B0:         v_d = w0_q;
          default:       v_d = x_q;
        endcase
        // history registers are loaded this cycle; the gain product takes the section input
        if (prod_q == PR_GAIN) v_d = x_q;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        p_d     = (p_q <<< 1) + addend;
        cbits_d = cbits_q << 1;
        bit_d   = bit_q + 5'd1;
        if (bit_q == 5'(COEF_W - 1)) state_d = ST_ACC;
      end
      ST_ACC: begin
        unique case (prod_q)
          PR_GAIN:      acc_d = ACC_W'(p_q);
          PR_A1, PR_A2: acc_d = acc_q - ACC_W'(p_q);
          default:      acc_d = acc_q + ACC_W'(p_q);
        endcase
        if (prod_q == PR_GAIN || prod_q == PR_A2 || prod_q == PR_B2) begin
          state_d = ST_RND;
        end else begin
          prod_d  = prod_q + 3'd1;
          state_d = ST_RD;
        end
      end
      ST_RND: begin
        unique case (prod_q)
          PR_GAIN: acc_d = ACC_W'(rnd) <<< Q_COEF;
          PR_A2: begin
            w0_d  = rnd;
            acc_d = '0;
          end
          default: begin
            x_d          = rnd;
            hv_d[sec_q]  = 1'b1;
          end
        endcase
        if (prod_q == PR_B2) begin
          prod_d = PR_GAIN;
          sec_d  = sec_q + SEC_W'(1);
          state_d = (CNT_W'(sec_q) + CNT_W'(1) == n_q) ? ST_OUT : ST_RD;
        end else begin
          prod_d  = prod_q + 3'd1;
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (fin_r > (SAMPLE_W+1)'(32767)) begin
            out_data_d = 16'h7fff;
            out_sat_d  = 1'b1;
          end else if (fin_r < -(SAMPLE_W+1)'(32768)) begin
            out_data_d = 16'h8000;
            out_sat_d  = 1'b1;
          end else begin
            out_data_d = fin_r[SAMPLE_W-1:0];
            out_sat_d  = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CNT_W'(RESET_COUNT);
      hv_q        <= '0;
      out_valid_q <= 1'b0;
      sec_q       <= '0;
      prod_q      <= PR_GAIN;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
      hv_q        <= hv_d;
      out_valid_q <= out_valid_d;
      sec_q       <= sec_d;
      prod_q      <= prod_d;
      bit_q       <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    cbits_q    <= cbits_d;
    x_q        <= x_d;
    w0_q       <= w0_d;
    h0_q       <= h0_d;
    h1_q       <= h1_d;
    v_q        <= v_d;
    p_q        <= p_d;
    acc_q      <= acc_d;
    out_sat_q  <= out_sat_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready_o)
    else $error("input accepted while busy");
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
    (m_axis_tdata_o == 16'h7fff || m_axis_tdata_o == 16'h8000))
    else $error("saturated flag on in-range sample");
  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (bit_q < 5'(COEF_W)))
    else $error("multiplier step count overrun");
  a_hist_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |=> hv_q[$past(sec_q)])
    else $error("history row written without valid bit");

endmodule

### bench/sic_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sic_tb_pkg: request codes shared by the cascade bench
// Codes carried on the input stream's tuser line.
// ----------------------------------------------------------------------------
package sic_tb_pkg;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

endpackage

### bench/sic_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sic_checker: cascade output predictor and scoreboard
// Watches the config port and both streams, runs its own fixed-point biquad
// cascade on every accepted sample and compares each output transfer with
// the oldest expected sample.
// ----------------------------------------------------------------------------
module sic_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [47:0] s_data_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,
  input  logic        m_user_i,
  output int          err_count_o,
  output int          pending_o
);
  import sic_pkg::*;
  import sic_tb_pkg::*;

  typedef struct packed {
    logic [15:0] sample_out;
    logic        saturated;
  } filt_out_t;

  longint    coef_mem [COEF_DEPTH];
  longint    hist_mem [2*MAX_SECTIONS];
  logic [5:0] active_count;
  filt_out_t expected_q [$];

  function automatic longint q22_round(input longint acc);
    longint t;
    t = (acc + (64'sd1 <<< (Q_COEF - 1))) >>> Q_COEF;
    if (t > 64'sd2147483647) return 64'sd2147483647;
    if (t < -64'sd2147483648) return -64'sd2147483648;
    return t;
  endfunction

  // push one sample through the active sections, updating the history
  function automatic filt_out_t filter_sample(input logic signed [15:0] smp);
    filt_out_t res;
    int n, base, hb;
    longint x, xs, w0, acc, r;
    n = (active_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(active_count);
    res.saturated = 1'b0;
    if (n == 0) begin
      res.sample_out = smp;
      return res;
    end
    x = longint'(smp) * 65536;
    for (int i = 0; i < n; i++) begin
      base = i * SLOTS;
      hb = 2 * i;
      xs = q22_round(x * coef_mem[base + int'(SLOT_GAIN)]);
      acc = (xs <<< Q_COEF) - coef_mem[base + int'(SLOT_A1)] * hist_mem[hb]
          - coef_mem[base + int'(SLOT_A2)] * hist_mem[hb+1];
      w0 = q22_round(acc);
      acc = coef_mem[base + int'(SLOT_B0)] * w0 + coef_mem[base + int'(SLOT_B1)] * hist_mem[hb]
          + coef_mem[base + int'(SLOT_B2)] * hist_mem[hb+1];
      x = q22_round(acc);
      hist_mem[hb+1] = hist_mem[hb];
      hist_mem[hb] = w0;
    end
    r = (x + 32768) >>> 16;
    if (r > 32767) begin
      r = 32767;
      res.saturated = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      res.saturated = 1'b1;
    end
    res.sample_out = r[15:0];
    return res;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_out_t got, want;
    int sec, slot;
    if (!rst_ni) begin
      active_count = 6'(RESET_COUNT);
      foreach (hist_mem[i]) hist_mem[i] = 0;
      foreach (coef_mem[i]) coef_mem[i] = 0;
      expected_q.delete();
      err_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) active_count = cfg_wdata_i;
      if (s_valid_i && s_ready_i) begin
        if (s_user_i == REQ_COEF) begin
          sec = int'(s_data_i[20:16]);
          slot = int'(s_data_i[23:21]);
          // drop writes to slots past the gain
          if (sec < MAX_SECTIONS && slot < SLOTS)
            coef_mem[sec*SLOTS + slot] = longint'($signed(s_data_i[47:24]));
        end else begin
          expected_q.push_back(filter_sample(s_data_i[15:0]));
        end
      end
      if (m_valid_i && m_ready_i) begin
        got.sample_out = m_data_i;
        got.saturated = m_user_i;
        if (expected_q.size() == 0) begin
          report("unexpected output", $signed(got.sample_out), 0);
        end else begin
          want = expected_q.pop_front();
          if (got.sample_out !== want.sample_out)
            report("sample_out", $signed(got.sample_out), $signed(want.sample_out));
          if (got.saturated !== want.saturated)
            report("saturated", longint'(got.saturated), longint'(want.saturated));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: biquad cascade testbench
// Loads every section's coefficients, then filters directed and random
// samples across several section counts with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  import sic_pkg::*;
  import sic_tb_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [47:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_user;
  int          err_count, pending;
  bit          quiet = 0;
  bit          hold_req = 0;
  int          cycles = 0;

  sos_iir_cascade_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user), .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  sic_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    int gap_left, hold_left;
    bit hold_done;
    gap_left = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (!rst_ni) begin
        m_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic user, input logic [15:0] smp, input logic [4:0] sec,
                      input logic [2:0] slot, input logic [23:0] val);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= user;
    s_data <= {val, slot, sec, smp};
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic send_sample(input logic [15:0] smp);
    send(REQ_SAMPLE, smp, 5'($urandom), 3'($urandom), 24'($urandom));
  endtask

  task automatic send_coef(input logic [4:0] sec, input logic [2:0] slot, input logic [23:0] val);
    send(REQ_COEF, 16'($urandom), sec, slot, val);
  endtask

  // coefficient that keeps a section stable: small feedback, gain from 0.5 to just under 2
  function automatic logic [23:0] tame_coef(input logic [2:0] slot);
    unique case (slot)
      SLOT_GAIN: return 24'($urandom_range(1 << 21, (1 << 23) - 1));
      SLOT_A2:   return 24'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default:   return 24'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  task automatic random_item(input int sample_pct);
    int pick;
    logic [2:0] slot;
    pick = $urandom_range(0, 99);
    if (pick < sample_pct) begin
      if ($urandom_range(0, 3) == 0) send_sample(16'(int'($urandom_range(0, 512)) - 256));
      else send_sample(16'($urandom));
    end else begin
      pick = $urandom_range(0, 9);
      slot = 3'($urandom_range(0, SLOTS - 1));
      if (pick < 7) send_coef(5'($urandom), slot, tame_coef(slot));
      else if (pick < 9) send_coef(5'($urandom), slot, 24'($urandom));
      else send_coef(5'($urandom), 3'($urandom_range(SLOTS, 7)), 24'($urandom));
    end
  endtask

  task automatic settle_and_set(input logic [5:0] count);
    s_valid <= 1'b0;
    // let the checker take the last transfer before looking at its queue
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [5:0] count, input int items);
    settle_and_set(count);
    repeat (items) random_item(80);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every section before any sample is filtered
    for (int sec = 0; sec < MAX_SECTIONS; sec++) begin
      for (int slot = 0; slot < SLOTS; slot++)
        send_coef(5'(sec), 3'(slot), tame_coef(3'(slot)));
    end

    // directed, at the reset section count
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_coef(5'd31, 3'd6, 24'hFFFFFF);
    send_coef(5'd31, 3'd7, 24'h7FFFFF);
    send_coef(5'd0, SLOT_GAIN, 24'h7FFFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_coef(5'd0, SLOT_GAIN, 24'h800000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_coef(5'd0, SLOT_GAIN, tame_coef(SLOT_GAIN));
    send_sample(16'h1234);
    repeat (45) random_item(80);

    run_phase(6'd0, 100);
    settle_and_set(6'd1);
    hold_req = 1;
    repeat (150) random_item(80);
    run_phase(6'd63, 12);
    run_phase(6'd2, 100);
    run_phase(6'd32, 12);
    run_phase(6'd3, 100);
    quiet = 1;
    run_phase(6'd6, 100);
    s_valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sic_pkg.sv
rtl/sic_ram.sv
rtl/sos_iir_cascade_unit.sv
bench/sic_tb_pkg.sv
bench/sic_checker.sv
bench/tb.sv
